/* sv/erams_pkg.sv */
// shared types and constants for the eight-register machine step block
// no dependencies; imported by erams_regfile, erams_exec and the top level
package erams_pkg;

  localparam int DEFAULT_REGISTER_COUNT = 8;
  localparam int DEFAULT_PROGRAM_DEPTH  = 128;

  localparam int OP_W      = 4;
  localparam int REG_IDX_W = 3;
  localparam int DATA_W    = 32;
  localparam int PTR_W     = 8;
  localparam logic [PTR_W-1:0] PTR_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_SHL = 4'd2,
    OP_SHR = 4'd3,
    OP_SET = 4'd4,
    OP_AND = 4'd5,
    OP_OR  = 4'd6,
    OP_J   = 4'd7,
    OP_PRT = 4'd8
  } op_t;

  // one decoded instruction, packed in tdata order (lowest field last here)
  typedef struct packed {
    logic signed [DATA_W-1:0]    immediate;
    logic [REG_IDX_W-1:0]        source_register;
    logic                        source_is_register;
    logic [REG_IDX_W-1:0]        first_register;
    logic                        first_is_register;
    logic [OP_W-1:0]             operation;
  } instr_t;

  // what the execute logic hands back for one instruction
  typedef struct packed {
    logic                        error;
    logic                        print_valid;
    logic                        print_is_literal;
    logic [DATA_W-1:0]           print_value;
    logic [PTR_W-1:0]            next_pointer;
    logic                        finished;
    logic                        wr_en;
    logic [REG_IDX_W-1:0]        wr_addr;
    logic [DATA_W-1:0]           wr_data;
  } exec_result_t;

endpackage

/* sv/erams_regfile.sv */
// register file memory: two registered read ports, one write port
// valid bits stand in for the all-zero reset; last write is forwarded
// depends on erams_pkg
module erams_regfile #(
  parameter int REGISTER_COUNT = erams_pkg::DEFAULT_REGISTER_COUNT,
  localparam int AW = $clog2(REGISTER_COUNT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr_a,
  input  logic [AW-1:0]               rd_addr_b,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [erams_pkg::DATA_W-1:0] wr_data,
  output logic [erams_pkg::DATA_W-1:0] rd_data_a,
  output logic [erams_pkg::DATA_W-1:0] rd_data_b
);
  import erams_pkg::*;

  logic [DATA_W-1:0]         mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] valid;

  logic [DATA_W-1:0] mem_q_a;
  logic [DATA_W-1:0] mem_q_b;
  logic              valid_q_a;
  logic              valid_q_b;
  logic [AW-1:0]     addr_q_a;
  logic [AW-1:0]     addr_q_b;

  logic              last_wr_valid;
  logic [AW-1:0]     last_wr_addr;
  logic [DATA_W-1:0] last_wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_a <= mem[rd_addr_a];
      mem_q_b <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      last_wr_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
        last_wr_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_wr_addr <= wr_addr;
      last_wr_data <= wr_data;
    end
    if (rd_en) begin
      valid_q_a <= valid[rd_addr_a];
      valid_q_b <= valid[rd_addr_b];
      addr_q_a  <= rd_addr_a;
      addr_q_b  <= rd_addr_b;
    end
  end

  // the most recent write always holds the current value of its entry
  always_comb begin
    if (last_wr_valid && last_wr_addr == addr_q_a) begin
      rd_data_a = last_wr_data;
    end else begin
      rd_data_a = valid_q_a ? mem_q_a : '0;
    end
    if (last_wr_valid && last_wr_addr == addr_q_b) begin
      rd_data_b = last_wr_data;
    end else begin
      rd_data_b = valid_q_b ? mem_q_b : '0;
    end
  end

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> valid[$past(wr_addr)])
    else $error("written entry not marked valid");

endmodule

/* sv/erams_exec.sv */
// execute logic: alu, pointer update, print and error decisions
// depends on erams_pkg
module erams_exec #(
  parameter int REGISTER_COUNT = erams_pkg::DEFAULT_REGISTER_COUNT
) (
  input  erams_pkg::instr_t             instr,
  input  logic [erams_pkg::DATA_W-1:0]  reg_a,
  input  logic [erams_pkg::DATA_W-1:0]  reg_b,
  input  logic [erams_pkg::PTR_W-1:0]   pointer,
  input  logic [erams_pkg::PTR_W-1:0]   program_length,
  output erams_pkg::exec_result_t       result
);
  import erams_pkg::*;

  logic              first_ok;
  logic              src_ok;
  logic [DATA_W-1:0] imm;
  logic [DATA_W-1:0] b;
  logic [4:0]        amt;
  logic [DATA_W-1:0] alu;
  logic [PTR_W-1:0]  inc_ptr;
  logic [PTR_W-1:0]  jump_ptr;

  assign first_ok = instr.first_is_register
                    && (32'(instr.first_register) < 32'(REGISTER_COUNT));
  assign src_ok   = instr.source_is_register
                    && (32'(instr.source_register) < 32'(REGISTER_COUNT));
  assign imm      = instr.immediate;
  assign b        = src_ok ? reg_b : imm;
  assign amt      = b[4:0];
  assign inc_ptr  = (pointer != PTR_MAX) ? pointer + PTR_W'(1) : pointer;
  // targets above the pointer range, negatives included, saturate
  assign jump_ptr = (|imm[DATA_W-1:PTR_W]) ? PTR_MAX : imm[PTR_W-1:0];

  always_comb begin
    case (instr.operation)
      OP_ADD:  alu = reg_a + b;
      OP_SUB:  alu = reg_a - b;
      OP_SHL:  alu = reg_a << amt;
      OP_SHR:  alu = DATA_W'($signed(reg_a) >>> amt);
      OP_SET:  alu = b;
      OP_AND:  alu = reg_a & b;
      OP_OR:   alu = reg_a | b;
      default: alu = b;
    endcase
  end

  always_comb begin
    result                  = '0;
    result.wr_addr          = instr.first_register;
    result.wr_data          = alu;
    result.next_pointer     = pointer;
    case (instr.operation)
      OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_SET, OP_AND, OP_OR: begin
        if (first_ok) begin
          result.wr_en        = 1'b1;
          result.next_pointer = inc_ptr;
        end else begin
          result.error        = 1'b1;
        end
      end
      OP_J: begin
        if (first_ok) begin
          result.error        = 1'b1;
        end else begin
          result.next_pointer = jump_ptr;
        end
      end
      OP_PRT: begin
        result.print_valid      = 1'b1;
        result.print_is_literal = !first_ok;
        result.print_value      = first_ok ? reg_a : imm;
        result.next_pointer     = inc_ptr;
      end
      default: begin
        result.error = 1'b1;
      end
    endcase
    result.finished = (result.next_pointer >= program_length);
  end

endmodule

/* sv/eight_register_alu_machine_step.sv */
// top level of the eight-register machine step block
// depends on erams_pkg, erams_regfile and erams_exec
//
// Executes one decoded instruction per request and returns one result per
// request. It sustains one instruction per clock cycle while the output is
// not stalled: an accepted request issues its register reads into the
// register file memory, whose read ports are registered, is executed and
// written back when it advances out of the execute stage, and its result
// then sits in the output register. Back-to-back dependent instructions are
// covered by forwarding the last register write. The register file clears
// through per-entry valid bits, so no clearing pass is needed after reset.
// The program_length write port is ready whenever reset is low and should
// only be written while no request is in flight.
module eight_register_alu_machine_step #(
  parameter int REGISTER_COUNT = erams_pkg::DEFAULT_REGISTER_COUNT,
  parameter int PROGRAM_DEPTH  = erams_pkg::DEFAULT_PROGRAM_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[3:0], first_is_register[4], first_register[7:5],
  // source_is_register[8], source_register[11:9], immediate[43:12], zeros
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // error[0], print_valid[1], print_is_literal[2], print_value[34:3],
  // next_pointer[42:35], finished[43], zeros
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [erams_pkg::PTR_W-1:0] cfg_data
);
  import erams_pkg::*;

  localparam int AW     = $clog2(REGISTER_COUNT);
  localparam int INST_W = $bits(instr_t);

  instr_t            in_instr;
  instr_t            ex_instr;
  logic              ex_valid;
  logic              accept;
  logic              advance;
  logic [PTR_W-1:0]  pointer;
  logic [PTR_W-1:0]  program_length;
  logic [DATA_W-1:0] reg_a;
  logic [DATA_W-1:0] reg_b;
  exec_result_t      res;

  logic              out_valid;
  logic              out_error;
  logic              out_print_valid;
  logic              out_print_is_literal;
  logic [DATA_W-1:0] out_print_value;
  logic [PTR_W-1:0]  out_next_pointer;
  logic              out_finished;

  assign in_instr      = s_axis_tdata[INST_W-1:0];
  assign advance       = ex_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!ex_valid || advance);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = !rst;

  erams_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (AW'(in_instr.first_register)),
    .rd_addr_b (AW'(in_instr.source_register)),
    .wr_en     (advance && res.wr_en),
    .wr_addr   (AW'(res.wr_addr)),
    .wr_data   (res.wr_data),
    .rd_data_a (reg_a),
    .rd_data_b (reg_b)
  );

  erams_exec #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_exec (
    .instr          (ex_instr),
    .reg_a          (reg_a),
    .reg_b          (reg_b),
    .pointer        (pointer),
    .program_length (program_length),
    .result         (res)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid       <= 1'b0;
      out_valid      <= 1'b0;
      pointer        <= '0;
      program_length <= '0;
    end else begin
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (advance) begin
        ex_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        pointer   <= res.next_pointer;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        program_length <= (cfg_data > PTR_W'(PROGRAM_DEPTH)) ? PTR_W'(PROGRAM_DEPTH)
                                                               : cfg_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_instr <= in_instr;
    end
    if (advance) begin
      out_error            <= res.error;
      out_print_valid      <= res.print_valid;
      out_print_is_literal <= res.print_is_literal;
      out_print_value      <= res.print_value;
      out_next_pointer     <= res.next_pointer;
      out_finished         <= res.finished;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_finished, out_next_pointer, out_print_value,
                          out_print_is_literal, out_print_valid, out_error};

  a_error_keeps_pointer: assert property (@(posedge clk) disable iff (rst)
    advance && res.error |=> pointer == $past(pointer))
    else $error("pointer moved on an invalid instruction");

  a_error_no_write: assert property (@(posedge clk) disable iff (rst)
    advance && res.error |-> !res.wr_en && !res.print_valid)
    else $error("invalid instruction changed state or printed");

  a_stalled_instr_kept: assert property (@(posedge clk) disable iff (rst)
    ex_valid && !advance |=> ex_valid && $stable(ex_instr))
    else $error("stalled instruction lost");

  a_print_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_print_valid |-> out_print_value == '0 && !out_print_is_literal)
    else $error("print fields set without a print");

  a_pointer_matches_output: assert property (@(posedge clk) disable iff (rst)
    $past(advance) && !$past(rst) |-> out_next_pointer == pointer)
    else $error("reported pointer differs from pointer state");

endmodule

/* bench/testbench.sv */
// self-checking bench for eight_register_alu_machine_step: drives decoded instructions on the
// request stream and checks every result against a predictor of the register machine kept here
// depends on erams_pkg and the top level eight_register_alu_machine_step
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import erams_pkg::*;

  localparam int                 WATCHDOG_LIMIT = 5000;
  localparam int                 DRAIN_CYCLES   = 4;
  localparam logic [OP_W-1:0]    OP_UNKNOWN_LO  = OP_PRT + 4'd1;
  localparam logic [OP_W-1:0]    OP_UNKNOWN_HI  = 4'hF;
  localparam logic [PTR_W-1:0]   LENGTH_MAX     = PTR_W'(DEFAULT_PROGRAM_DEPTH);

  // one result as it sits on m_axis_tdata, lowest field last
  typedef struct packed {
    logic [3:0]        pad;
    logic              finished;
    logic [PTR_W-1:0]  next_pointer;
    logic [DATA_W-1:0] print_value;
    logic              print_is_literal;
    logic              print_valid;
    logic              error;
  } step_result_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [PTR_W-1:0] cfg_data;

  // predicted machine state
  logic [DATA_W-1:0] machine_regs [DEFAULT_REGISTER_COUNT];
  logic [PTR_W-1:0]  machine_ip;
  logic [PTR_W-1:0]  program_length_q;

  step_result_t pending_results[$];
  int mismatch_count;
  int send_idle_pct;
  int recv_idle_pct;
  int output_hold_cycles;
  int quiet_cycles;

  eight_register_alu_machine_step u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic instr_t make_instr(logic [OP_W-1:0] op, logic fir, logic [2:0] fr,
                                        logic sir, logic [2:0] sr, logic [31:0] imm);
    instr_t it;
    it.operation          = op;
    it.first_is_register  = fir;
    it.first_register     = fr;
    it.source_is_register = sir;
    it.source_register    = sr;
    it.immediate          = imm;
    return it;
  endfunction

  // applies one instruction to the predicted state and returns its result
  function automatic step_result_t execute_instr(instr_t it);
    step_result_t r;
    logic [PTR_W-1:0]  next_ip;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] v;
    r = '0;
    next_ip = (machine_ip != PTR_MAX) ? machine_ip + 8'd1 : PTR_MAX;
    a = machine_regs[it.first_register];
    b = it.source_is_register ? machine_regs[it.source_register] : it.immediate;
    case (it.operation)
      OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_SET, OP_AND, OP_OR: begin
        if (!it.first_is_register) begin
          r.error = 1'b1;
        end else begin
          case (it.operation)
            OP_ADD:  v = a + b;
            OP_SUB:  v = a - b;
            OP_SHL:  v = a << b[4:0];
            OP_SHR:  v = $signed(a) >>> b[4:0];
            OP_SET:  v = b;
            OP_AND:  v = a & b;
            default: v = a | b;
          endcase
          machine_regs[it.first_register] = v;
          machine_ip = next_ip;
        end
      end
      OP_J: begin
        if (it.first_is_register) begin
          r.error = 1'b1;
        end else begin
          // targets beyond the pointer range, negative ones too, pin at the top
          machine_ip = (it.immediate[31:8] != '0) ? PTR_MAX : it.immediate[7:0];
        end
      end
      OP_PRT: begin
        r.print_valid = 1'b1;
        if (it.first_is_register) begin
          r.print_value = machine_regs[it.first_register];
        end else begin
          r.print_is_literal = 1'b1;
          r.print_value      = it.immediate;
        end
        machine_ip = next_ip;
      end
      default: r.error = 1'b1;
    endcase
    r.next_pointer = machine_ip;
    r.finished     = machine_ip >= program_length_q;
    return r;
  endfunction

  function automatic instr_t random_instr();
    logic [OP_W-1:0] op;
    logic            fir;
    logic [31:0]     imm;
    if ($urandom_range(0, 99) < 8)
      op = OP_W'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
    else
      op = OP_W'($urandom_range(OP_ADD, OP_PRT));
    // mostly well-formed operands: register destinations, literal jump targets
    if (op == OP_J)
      fir = ($urandom_range(0, 99) < 10);
    else
      fir = ($urandom_range(0, 99) < 90);
    case ($urandom_range(0, 4))
      0, 1:    imm = $urandom;
      2:       imm = $urandom_range(0, 40);
      3:       imm = $urandom_range(0, 300);
      default: begin
        case ($urandom_range(0, 3))
          0:       imm = 32'h0000_0000;
          1:       imm = 32'hFFFF_FFFF;
          2:       imm = 32'h7FFF_FFFF;
          default: imm = 32'h8000_0000;
        endcase
      end
    endcase
    return make_instr(op, fir, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                      3'($urandom_range(0, 7)), imm);
  endfunction

  // offers one request, predicts it once it is taken
  task automatic send_instr(instr_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it};
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(execute_instr(it));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_program_length(logic [PTR_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    program_length_q = (value > LENGTH_MAX) ? LENGTH_MAX : value;
  endtask

  task automatic test_directed();
    send_idle_pct <= 20;
    recv_idle_pct <= 20;
    write_program_length(8'd5);
    send_instr(make_instr(OP_SET, 1'b1, 3'd0, 1'b0, 3'd0, 32'h7FFF_FFFF));
    send_instr(make_instr(OP_SET, 1'b1, 3'd7, 1'b0, 3'd0, 32'h8000_0000));
    send_instr(make_instr(OP_ADD, 1'b1, 3'd0, 1'b1, 3'd7, 32'h0));
    send_instr(make_instr(OP_ADD, 1'b1, 3'd0, 1'b0, 3'd0, 32'h1));         // wraps to zero
    send_instr(make_instr(OP_SUB, 1'b1, 3'd1, 1'b0, 3'd0, 32'h1));
    send_instr(make_instr(OP_SHL, 1'b1, 3'd1, 1'b0, 3'd0, 32'd33));        // amount uses low 5 bits
    send_instr(make_instr(OP_SET, 1'b1, 3'd3, 1'b0, 3'd0, 32'd3));
    send_instr(make_instr(OP_SHR, 1'b1, 3'd7, 1'b1, 3'd3, 32'h0));         // sign fills in
    send_instr(make_instr(OP_SHR, 1'b1, 3'd7, 1'b0, 3'd0, 32'h0));
    send_instr(make_instr(OP_AND, 1'b1, 3'd1, 1'b1, 3'd7, 32'h0));
    send_instr(make_instr(OP_OR,  1'b1, 3'd2, 1'b0, 3'd0, 32'h0000_00F0));
    send_instr(make_instr(OP_ADD, 1'b0, 3'd2, 1'b0, 3'd0, 32'h5));         // literal destination
    send_instr(make_instr(OP_J,   1'b1, 3'd0, 1'b0, 3'd0, 32'h3));         // register jump argument
    send_instr(make_instr(OP_J,   1'b0, 3'd0, 1'b0, 3'd0, 32'h3));
    send_instr(make_instr(OP_J,   1'b0, 3'd0, 1'b0, 3'd0, 32'd300));
    send_instr(make_instr(OP_SET, 1'b1, 3'd4, 1'b0, 3'd0, 32'h0));         // pointer held at top
    send_instr(make_instr(OP_PRT, 1'b1, 3'd4, 1'b0, 3'd0, 32'h0));
    send_instr(make_instr(OP_J,   1'b0, 3'd0, 1'b0, 3'd0, 32'hFFFF_FFFF)); // negative target
    send_instr(make_instr(OP_J,   1'b0, 3'd0, 1'b0, 3'd0, 32'h0));
    send_instr(make_instr(OP_PRT, 1'b0, 3'd0, 1'b0, 3'd0, 32'h8000_0000));
    send_instr(make_instr(OP_PRT, 1'b1, 3'd7, 1'b1, 3'd7, 32'h0));
    send_instr(make_instr(OP_SET, 1'b1, 3'd5, 1'b1, 3'd2, 32'h0));
    send_instr(make_instr(OP_UNKNOWN_LO, 1'b1, 3'd0, 1'b0, 3'd0, 32'h0));
    send_instr(make_instr(OP_UNKNOWN_HI, 1'b1, 3'd7, 1'b1, 3'd7, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_traffic(int count, int send_pct, int recv_pct,
                                     logic [PTR_W-1:0] length);
    write_program_length(length);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    repeat (count) send_instr(random_instr());
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_output_stall();
    write_program_length(PTR_W'($urandom_range(1, 127)));
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    output_hold_cycles <= 300;
    repeat (40) send_instr(random_instr());
  endtask

  // sender goes quiet until every result is back, then resumes
  task automatic test_pause_until_drained();
    write_program_length(8'd1);
    send_idle_pct <= 10;
    recv_idle_pct <= 10;
    repeat (20) send_instr(random_instr());
    wait_drained();
    repeat (20) send_instr(random_instr());
  endtask

  always @(posedge clk) begin
    if (output_hold_cycles != 0) begin
      m_axis_tready      <= 1'b0;
      output_hold_cycles <= output_hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %h got %h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    step_result_t want;
    step_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = step_result_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("error", 32'(want.error), 32'(got.error));
        check_field("print_valid", 32'(want.print_valid), 32'(got.print_valid));
        check_field("print_is_literal", 32'(want.print_is_literal),
                    32'(got.print_is_literal));
        check_field("print_value", want.print_value, got.print_value);
        check_field("next_pointer", 32'(want.next_pointer), 32'(got.next_pointer));
        check_field("finished", 32'(want.finished), 32'(got.finished));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                = 1'b1;
    s_axis_tvalid      = 1'b0;
    s_axis_tdata       = '0;
    m_axis_tready      = 1'b0;
    cfg_valid          = 1'b0;
    cfg_data           = '0;
    mismatch_count     = 0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    output_hold_cycles = 0;
    quiet_cycles       = 0;
    machine_ip         = '0;
    program_length_q   = '0;
    foreach (machine_regs[i]) machine_regs[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(500, 27, 75, LENGTH_MAX);
    test_random_traffic(500, 75, 27, 8'hFF);  // above the depth, saturates
    test_random_traffic(450, 0, 0, 8'd0);
    test_output_stall();
    test_pause_until_drained();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* eight_register_alu_machine_step.f */
sv/erams_pkg.sv
sv/erams_regfile.sv
sv/erams_exec.sv
sv/eight_register_alu_machine_step.sv
bench/testbench.sv
